@@ design/c8_pkg.sv @@
// ============================================================================
// c8_pkg: shared definitions for the CHIP-8 instruction subset core
// Memory geometry, font layout, result codes and storage request structs.
// ============================================================================
`default_nettype none

package c8_pkg;

    // Byte memory geometry. The size is a power of two, so addresses wrap
    // by dropping upper bits.
    localparam int MEM_BYTES  = 4096;
    localparam int MEM_ADDR_W = $clog2(MEM_BYTES);

    // Program counter and index register are always 12 bits wide.
    localparam int WORD_W = 12;

    localparam int FONT_BASE     = 80;
    localparam int FONT_STEP     = 5;
    localparam int PROGRAM_START = 512;

    // Item kinds on the input stream.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EXEC  = 1'b1;

    // Result status codes.
    localparam logic [2:0] STAT_EXECUTED   = 3'd0;
    localparam logic [2:0] STAT_STOPPED    = 3'd1;
    localparam logic [2:0] STAT_UNIMPL     = 3'd2;
    localparam logic [2:0] STAT_IGNORED    = 3'd3;
    localparam logic [2:0] STAT_WRITE_DONE = 3'd4;

    // Display request codes.
    localparam logic [1:0] DISP_NONE   = 2'd0;
    localparam logic [1:0] DISP_CLEAR  = 2'd1;
    localparam logic [1:0] DISP_DRAW   = 2'd2;
    localparam logic [1:0] DISP_RENDER = 2'd3;

    // Glyphs present in the reset image of memory, five rows each.
    localparam int GLYPH_COUNT = 5;
    localparam int GLYPH_ROWS  = 5;
    localparam logic [3:0] GLYPH_DIGIT [GLYPH_COUNT] = '{4'd0, 4'd1, 4'd2, 4'd7, 4'd8};
    localparam logic [7:0] GLYPH_DATA [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{8'h0F, 8'h09, 8'h09, 8'h09, 8'h0F},
        '{8'h04, 8'h06, 8'h04, 8'h04, 8'h04},
        '{8'h06, 8'h09, 8'h04, 8'h02, 8'h0F},
        '{8'h0F, 8'h08, 8'h04, 8'h02, 8'h01},
        '{8'h06, 8'h09, 8'h06, 8'h09, 8'h06}
    };

    // Reset content of one memory byte. Later glyphs win where two overlap.
    function automatic logic [7:0] font_byte(input logic [MEM_ADDR_W-1:0] addr);
        logic [7:0] value;
        int         place;
        value = 8'h00;
        for (int g = 0; g < GLYPH_COUNT; g++)
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                place = (FONT_BASE + FONT_STEP * int'(GLYPH_DIGIT[g]) + r) % MEM_BYTES;
                if (addr == MEM_ADDR_W'(place))
                begin
                    value = GLYPH_DATA[g][r];
                end
            end
        end
        return value;
    endfunction

    // Request to the byte memory: one write and one read address per cycle.
    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [7:0]            wdata;
        logic [MEM_ADDR_W-1:0] raddr;
    } mem_req_t;

    // Request to the register file: one write and two read addresses.
    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic [3:0] raddr_a;
        logic [3:0] raddr_b;
    } vreg_req_t;

endpackage

`default_nettype wire

@@ design/c8_store.sv @@
// ============================================================================
// c8_store: byte memory and V register file
// Two synchronous memories with registered read data.
// ============================================================================
`default_nettype none

module c8_store
    import c8_pkg::*;
(
    input  wire logic       clk,
    input  wire mem_req_t   mem_req,
    output logic [7:0]      mem_rdata,
    input  wire vreg_req_t  vreg_req,
    output logic [7:0]      vreg_rdata_a,
    output logic [7:0]      vreg_rdata_b
);

    logic [7:0] main_mem [MEM_BYTES];
    logic [7:0] vreg_mem [16];

    logic [7:0] mem_rd_reg;
    logic [7:0] vreg_rd_a_reg;
    logic [7:0] vreg_rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            main_mem[mem_req.waddr] <= mem_req.wdata;
        end
        mem_rd_reg <= main_mem[mem_req.raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vreg_req.we)
        begin
            vreg_mem[vreg_req.waddr] <= vreg_req.wdata;
        end
        vreg_rd_a_reg <= vreg_mem[vreg_req.raddr_a];
        vreg_rd_b_reg <= vreg_mem[vreg_req.raddr_b];
    end

    assign mem_rdata    = mem_rd_reg;
    assign vreg_rdata_a = vreg_rd_a_reg;
    assign vreg_rdata_b = vreg_rd_b_reg;

endmodule

`default_nettype wire

@@ design/chip8_instruction_subset_core.sv @@
// ============================================================================
// chip8_instruction_subset_core: CHIP-8 interpreter for a subset of opcodes
// Sequencer around a byte memory and a V register file.
// ============================================================================
// Each input transfer either writes one memory byte or executes the instruction
// at the program counter, and each yields exactly one result transfer. After
// reset the block sweeps the whole memory once, one byte per cycle, to load the
// font glyphs and zero the rest (and the V registers); no input transfer is
// taken during this sweep. A write item completes in the idle state. An execute
// item goes through fetch of two bytes through the single memory read port,
// register read and execute; FX33 adds the tens and ones states because its
// three digits go out through the single memory write port, and FX65 a load
// state per register and a tail, as it loads one register per memory read. A
// stopped core answers execute items in the idle state. Results sit in an output
// register, so the next input can be taken while the result is being handed off.
// ============================================================================
`default_nettype none

module chip8_instruction_subset_core
    import c8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // mem_address[11:0], mem_data[19:12], zero pad
    input  wire logic [0:0]  s_axis_tuser,   // opcode[0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // display_request[1:0], sprite_address[13:2],
                                             // sprite_x[21:14], sprite_y[29:22],
                                             // sprite_rows[33:30], fault_pc[45:34], zero pad
    output logic [2:0]       m_axis_tuser    // status[2:0]
);

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_FETCH_LO  = 4'd2;
    localparam logic [3:0] ST_DECODE    = 4'd3;
    localparam logic [3:0] ST_EXEC      = 4'd4;
    localparam logic [3:0] ST_BCD_TENS  = 4'd5;
    localparam logic [3:0] ST_BCD_ONES  = 4'd6;
    localparam logic [3:0] ST_LOAD      = 4'd7;
    localparam logic [3:0] ST_LOAD_TAIL = 4'd8;

    // Instruction classes by upper nibble, and low-byte selectors.
    localparam logic [3:0] NIB_SYS      = 4'h0;
    localparam logic [3:0] NIB_SET      = 4'h6;
    localparam logic [3:0] NIB_ADD      = 4'h7;
    localparam logic [3:0] NIB_LOAD_I   = 4'hA;
    localparam logic [3:0] NIB_DRAW     = 4'hD;
    localparam logic [3:0] NIB_MISC     = 4'hF;
    localparam logic [7:0] LO_CLS       = 8'hE0;
    localparam logic [7:0] LO_RENDER    = 8'h00;
    localparam logic [7:0] LO_FONT      = 8'h29;
    localparam logic [7:0] LO_BCD       = 8'h33;
    localparam logic [7:0] LO_LOAD      = 8'h65;

    // Control state.
    logic [3:0]            state_reg, state_next;
    logic [MEM_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [WORD_W-1:0]     pc_reg, pc_next;
    logic [WORD_W-1:0]     idx_reg, idx_next;
    logic                  stopped_reg, stopped_next;
    logic [3:0]            ld_cnt_reg, ld_cnt_next;
    logic                  ld_pend_reg, ld_pend_next;
    logic                  out_valid_reg, out_valid_next;

    // Working registers for the instruction in flight.
    logic [7:0]            hi_reg, hi_next;
    logic [7:0]            lo_reg, lo_next;
    logic [3:0]            ld_idx_reg, ld_idx_next;
    logic [3:0]            tens_reg, tens_next;
    logic [3:0]            ones_reg, ones_next;

    // Output register.
    logic [2:0]            out_status_reg;
    logic [1:0]            out_disp_reg;
    logic [WORD_W-1:0]     out_saddr_reg;
    logic [7:0]            out_sx_reg;
    logic [7:0]            out_sy_reg;
    logic [3:0]            out_rows_reg;
    logic [WORD_W-1:0]     out_fpc_reg;

    // Result being produced this cycle.
    logic                  res_load;
    logic                  exec_done;
    logic [2:0]            res_status;
    logic [1:0]            res_disp;
    logic [WORD_W-1:0]     res_saddr;
    logic [7:0]            res_sx;
    logic [7:0]            res_sy;
    logic [3:0]            res_rows;
    logic [WORD_W-1:0]     res_fpc;

    // Storage interface.
    mem_req_t              mem_req;
    vreg_req_t             vreg_req;
    logic [7:0]            mem_rdata;
    logic [7:0]            vx;
    logic [7:0]            vy;

    // Input fields.
    logic                  in_accept;
    logic                  in_op;
    logic [WORD_W-1:0]     in_addr;
    logic [7:0]            in_data;

    // Address and arithmetic helpers.
    logic [WORD_W-1:0]     pc_plus1;
    logic [WORD_W-1:0]     pc_plus2;
    logic [WORD_W-1:0]     idx_plus1;
    logic [WORD_W-1:0]     idx_plus2;
    logic [WORD_W-1:0]     idx_plus_cnt;
    logic [15:0]           font_addr;
    logic [1:0]            bcd_hund;
    logic [7:0]            bcd_rem;
    logic [14:0]           bcd_tens_prod;
    logic [3:0]            bcd_tens;
    logic [6:0]            bcd_ones;

    c8_store u_store (
        .clk          (clk),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .vreg_req     (vreg_req),
        .vreg_rdata_a (vx),
        .vreg_rdata_b (vy)
    );

    assign in_op   = s_axis_tuser[0];
    assign in_addr = s_axis_tdata[11:0];
    assign in_data = s_axis_tdata[19:12];

    // Input is taken only between instructions and only when the output
    // register is empty or is being emptied in this same cycle.
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign pc_plus1     = pc_reg + WORD_W'(1);
    assign pc_plus2     = pc_reg + WORD_W'(2);
    assign idx_plus1    = idx_reg + WORD_W'(1);
    assign idx_plus2    = idx_reg + WORD_W'(2);
    assign idx_plus_cnt = idx_reg + {{(WORD_W-4){1'b0}}, ld_cnt_reg};

    // FX29: glyph address of VX.
    assign font_addr = 16'(FONT_BASE) + 16'(FONT_STEP) * {8'h00, vx};

    // FX33: hundreds by comparison, tens by reciprocal multiply (valid below
    // 1029), ones by subtraction.
    assign bcd_hund      = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
    assign bcd_rem       = vx - ({6'b0, bcd_hund} * 8'd100);
    assign bcd_tens_prod = {8'b0, bcd_rem[6:0]} * 15'd205;
    assign bcd_tens      = bcd_tens_prod[14:11];
    assign bcd_ones      = bcd_rem[6:0] - ({3'b0, bcd_tens} * 7'd10);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pc_next       = pc_reg;
        idx_next      = idx_reg;
        stopped_next  = stopped_reg;
        ld_cnt_next   = ld_cnt_reg;
        ld_pend_next  = ld_pend_reg;
        ld_idx_next   = ld_idx_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        tens_next     = tens_reg;
        ones_next     = ones_reg;

        mem_req        = '0;
        mem_req.raddr  = pc_reg[MEM_ADDR_W-1:0];
        vreg_req       = '0;

        res_load   = 1'b0;
        exec_done  = 1'b0;
        res_status = STAT_EXECUTED;
        res_disp   = DISP_NONE;
        res_saddr  = '0;
        res_sx     = '0;
        res_sy     = '0;
        res_rows   = '0;
        res_fpc    = pc_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // One byte per cycle; the first sixteen addresses also zero V.
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                mem_req.wdata = font_byte(clr_addr_reg);
                if (clr_addr_reg < MEM_ADDR_W'(16))
                begin
                    vreg_req.we    = 1'b1;
                    vreg_req.waddr = clr_addr_reg[3:0];
                    vreg_req.wdata = 8'h00;
                end
                clr_addr_next = clr_addr_reg + MEM_ADDR_W'(1);
                if (clr_addr_reg == {MEM_ADDR_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_op == OP_WRITE)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = in_addr[MEM_ADDR_W-1:0];
                        mem_req.wdata = in_data;
                        res_load      = 1'b1;
                        res_status    = STAT_WRITE_DONE;
                        res_fpc       = '0;
                    end
                    else if (stopped_reg)
                    begin
                        res_load   = 1'b1;
                        res_status = STAT_IGNORED;
                    end
                    else
                    begin
                        // High opcode byte is read at pc here.
                        state_next = ST_FETCH_LO;
                    end
                end
            end

            ST_FETCH_LO:
            begin
                mem_req.raddr = pc_plus1[MEM_ADDR_W-1:0];
                hi_next       = mem_rdata;
                state_next    = ST_DECODE;
            end

            ST_DECODE:
            begin
                lo_next          = mem_rdata;
                vreg_req.raddr_a = hi_reg[3:0];
                vreg_req.raddr_b = mem_rdata[7:4];
                state_next       = ST_EXEC;
            end

            ST_EXEC:
            begin
                exec_done = 1'b1;
                unique case (hi_reg[7:4])
                    NIB_SYS:
                    begin
                        if ((hi_reg == 8'h00) && (lo_reg == LO_CLS))
                        begin
                            res_disp = DISP_CLEAR;
                        end
                        else
                        begin
                            res_status = STAT_UNIMPL;
                        end
                    end
                    NIB_SET:
                    begin
                        vreg_req.we    = 1'b1;
                        vreg_req.waddr = hi_reg[3:0];
                        vreg_req.wdata = lo_reg;
                    end
                    NIB_ADD:
                    begin
                        vreg_req.we    = 1'b1;
                        vreg_req.waddr = hi_reg[3:0];
                        vreg_req.wdata = vx + lo_reg;
                    end
                    NIB_LOAD_I:
                    begin
                        idx_next = {hi_reg[3:0], lo_reg};
                    end
                    NIB_DRAW:
                    begin
                        res_disp  = DISP_DRAW;
                        res_saddr = idx_reg;
                        res_sx    = vx;
                        res_sy    = vy;
                        res_rows  = lo_reg[3:0];
                    end
                    NIB_MISC:
                    begin
                        unique case (lo_reg)
                            LO_RENDER:
                            begin
                                res_disp   = DISP_RENDER;
                                res_status = STAT_STOPPED;
                            end
                            LO_FONT:
                            begin
                                idx_next = font_addr[WORD_W-1:0];
                            end
                            LO_BCD:
                            begin
                                // Hundreds go out now, tens and ones in the
                                // BCD_TENS and BCD_ONES states that follow.
                                exec_done     = 1'b0;
                                mem_req.we    = 1'b1;
                                mem_req.waddr = idx_reg[MEM_ADDR_W-1:0];
                                mem_req.wdata = {6'b0, bcd_hund};
                                tens_next     = bcd_tens;
                                ones_next     = bcd_ones[3:0];
                                state_next    = ST_BCD_TENS;
                            end
                            LO_LOAD:
                            begin
                                exec_done    = 1'b0;
                                ld_cnt_next  = 4'd0;
                                ld_pend_next = 1'b0;
                                state_next   = ST_LOAD;
                            end
                            default:
                            begin
                                res_status = STAT_UNIMPL;
                            end
                        endcase
                    end
                    default:
                    begin
                        res_status = STAT_UNIMPL;
                    end
                endcase
            end

            ST_BCD_TENS:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_plus1[MEM_ADDR_W-1:0];
                mem_req.wdata = {4'b0, tens_reg};
                state_next    = ST_BCD_ONES;
            end

            ST_BCD_ONES:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_plus2[MEM_ADDR_W-1:0];
                mem_req.wdata = {4'b0, ones_reg};
                exec_done     = 1'b1;
            end

            ST_LOAD:
            begin
                // Read byte I+cnt while the byte read last cycle lands in V.
                mem_req.raddr = idx_plus_cnt[MEM_ADDR_W-1:0];
                if (ld_pend_reg)
                begin
                    vreg_req.we    = 1'b1;
                    vreg_req.waddr = ld_idx_reg;
                    vreg_req.wdata = mem_rdata;
                end
                ld_pend_next = 1'b1;
                ld_idx_next  = ld_cnt_reg;
                if (ld_cnt_reg == hi_reg[3:0])
                begin
                    state_next = ST_LOAD_TAIL;
                end
                else
                begin
                    ld_cnt_next = ld_cnt_reg + 4'd1;
                end
            end

            ST_LOAD_TAIL:
            begin
                vreg_req.we    = 1'b1;
                vreg_req.waddr = ld_idx_reg;
                vreg_req.wdata = mem_rdata;
                exec_done      = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Completion of an executed instruction: advance or stop in place.
        if (exec_done)
        begin
            res_load   = 1'b1;
            state_next = ST_IDLE;
            if (res_status == STAT_EXECUTED)
            begin
                pc_next = pc_plus2;
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pc_reg        <= WORD_W'(PROGRAM_START);
            idx_reg       <= '0;
            stopped_reg   <= 1'b0;
            ld_cnt_reg    <= '0;
            ld_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            stopped_reg   <= stopped_next;
            ld_cnt_reg    <= ld_cnt_next;
            ld_pend_reg   <= ld_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        ld_idx_reg <= ld_idx_next;
        tens_reg   <= tens_next;
        ones_reg   <= ones_next;
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_disp_reg   <= res_disp;
            out_saddr_reg  <= res_saddr;
            out_sx_reg     <= res_sx;
            out_sy_reg     <= res_sy;
            out_rows_reg   <= res_rows;
            out_fpc_reg    <= res_fpc;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b00, out_fpc_reg, out_rows_reg, out_sy_reg, out_sx_reg,
                            out_saddr_reg, out_disp_reg};

endmodule

`default_nettype wire

@@ design/c8_checker.sv @@
// ============================================================================
// c8_checker: port-level checks for the CHIP-8 instruction subset core
// Watches the stream ports and is bound to the top level.
// ============================================================================
`default_nettype none

module c8_checker
    import c8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic [0:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic [2:0]  m_axis_tuser
);

    // A stalled result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A new input is never taken while an undelivered result would be lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("input taken over a pending result");

    // Draw and clear requests come from executed instructions; a render
    // request always stops the core.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[1:0] == DISP_DRAW) ||
                          (m_axis_tdata[1:0] == DISP_CLEAR)) |->
            m_axis_tuser == STAT_EXECUTED)
        else $error("display request with a wrong status");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == DISP_RENDER) |-> m_axis_tuser == STAT_STOPPED)
        else $error("render request without a stop");

    // A completed memory write carries no other information.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_WRITE_DONE) |-> m_axis_tdata == 48'h0)
        else $error("write result with nonzero fields");

endmodule

bind chip8_instruction_subset_core c8_checker u_c8_checker (.*);

`default_nettype wire

@@ tb/chip8_result_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// chip8_result_checker: result predictor and scoreboard for the CHIP-8 core
// Watches both stream channels. Every input transfer runs through a local
// copy of the interpreter state, and every result transfer is compared field
// by field with the oldest predicted outcome.
// ============================================================================

package chip8_isa_pkg;

    // Instruction groups (upper nibble of the first instruction byte).
    localparam logic [3:0] GRP_SYS   = 4'h0;
    localparam logic [3:0] GRP_SET   = 4'h6;
    localparam logic [3:0] GRP_ADD   = 4'h7;
    localparam logic [3:0] GRP_ALU   = 4'h8;
    localparam logic [3:0] GRP_INDEX = 4'hA;
    localparam logic [3:0] GRP_DRAW  = 4'hD;
    localparam logic [3:0] GRP_MISC  = 4'hF;

    // Second instruction byte of the system and miscellaneous groups.
    localparam logic [7:0] SYS_CLS   = 8'hE0;
    localparam logic [7:0] SYS_RET   = 8'hEE;
    localparam logic [7:0] MISC_HALT = 8'h00;
    localparam logic [7:0] MISC_KEY  = 8'h0A;
    localparam logic [7:0] MISC_FONT = 8'h29;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_LOAD = 8'h65;

endpackage

module chip8_result_checker
    import c8_pkg::*;
    import chip8_isa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    output int               open_count,
    output int               error_count
);

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  display;
        logic [11:0] sprite_address;
        logic [7:0]  sprite_x;
        logic [7:0]  sprite_y;
        logic [3:0]  sprite_rows;
        logic [11:0] fault_pc;
    } outcome_t;

    logic [7:0]  image [MEM_BYTES];
    logic [7:0]  vreg [16];
    logic [11:0] index_reg;
    logic [11:0] pc;
    logic        halted;

    outcome_t pending_outcomes [$];
    int       fail_total;

    // Applies one input item to the interpreter state and returns its result.
    function automatic outcome_t interpret_item(input logic kind, input logic [11:0] addr,
                                                input logic [7:0] value);
        outcome_t    res;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [11:0] a;
        int          v;
        res = '0;
        if (kind == OP_WRITE)
        begin
            image[addr] = value;
            res.status = STAT_WRITE_DONE;
            return res;
        end
        res.fault_pc = pc;
        if (halted)
        begin
            res.status = STAT_IGNORED;
            return res;
        end
        a = pc + 12'd1;
        hi = image[pc];
        lo = image[a];
        x = hi[3:0];
        y = lo[7:4];
        res.status = STAT_EXECUTED;
        case (hi[7:4])
            GRP_SYS:
            begin
                if (x == 4'h0 && lo == SYS_CLS)
                    res.display = DISP_CLEAR;
                else
                    res.status = STAT_UNIMPL;
            end
            GRP_SET:   vreg[x] = lo;
            GRP_ADD:   vreg[x] = vreg[x] + lo;
            GRP_INDEX: index_reg = {x, lo};
            GRP_DRAW:
            begin
                res.display = DISP_DRAW;
                res.sprite_address = index_reg;
                res.sprite_x = vreg[x];
                res.sprite_y = vreg[y];
                res.sprite_rows = lo[3:0];
            end
            GRP_MISC:
            begin
                case (lo)
                    MISC_HALT:
                    begin
                        res.display = DISP_RENDER;
                        res.status = STAT_STOPPED;
                    end
                    MISC_FONT: index_reg = 12'(FONT_BASE + FONT_STEP * int'(vreg[x]));
                    MISC_BCD:
                    begin
                        v = int'(vreg[x]);
                        image[index_reg] = 8'(v / 100);
                        a = index_reg + 12'd1;
                        image[a] = 8'((v % 100) / 10);
                        a = index_reg + 12'd2;
                        image[a] = 8'(v % 10);
                    end
                    MISC_LOAD:
                    begin
                        for (int i = 0; i <= int'(x); i++)
                        begin
                            a = index_reg + 12'(i);
                            vreg[i] = image[a];
                        end
                    end
                    default: res.status = STAT_UNIMPL;
                endcase
            end
            default: res.status = STAT_UNIMPL;
        endcase
        if (res.status != STAT_EXECUTED)
            halted = 1'b1;
        else
            pc = pc + 12'd2;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_BYTES; i++)
                image[i] = 8'h00;
            for (int g = 0; g < GLYPH_COUNT; g++)
                for (int r = 0; r < GLYPH_ROWS; r++)
                    image[12'(FONT_BASE + FONT_STEP * int'(GLYPH_DIGIT[g]) + r)] =
                        GLYPH_DATA[g][r];
            for (int i = 0; i < 16; i++)
                vreg[i] = 8'h00;
            index_reg = '0;
            pc = 12'(PROGRAM_START);
            halted = 1'b0;
            pending_outcomes.delete();
            fail_total = 0;
            open_count <= 0;
            error_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pending_outcomes.push_back(interpret_item(s_tuser[0], s_tdata[11:0],
                                                          s_tdata[19:12]));
            if (m_tvalid && m_tready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result transfer with no outstanding item, status %0d", m_tuser);
                    fail_total++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("display_request", want.display, m_tdata[1:0]);
                    check_field("sprite_address", want.sprite_address, m_tdata[13:2]);
                    check_field("sprite_x", want.sprite_x, m_tdata[21:14]);
                    check_field("sprite_y", want.sprite_y, m_tdata[29:22]);
                    check_field("sprite_rows", want.sprite_rows, m_tdata[33:30]);
                    check_field("fault_pc", want.fault_pc, m_tdata[45:34]);
                end
            end
            open_count <= pending_outcomes.size();
            error_count <= fail_total;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for chip8_instruction_subset_core
// Feeds memory writes and instruction executions through the input stream and
// leaves all checking to chip8_result_checker, which sits beside the core.
// ============================================================================

module testbench;
    import c8_pkg::*;
    import chip8_isa_pkg::*;

    localparam int CYCLE_LIMIT      = 1_000_000;
    // Length of the single long stall of the result channel.
    localparam int LONG_HOLD_CYCLES = 400;
    // The input transfer counts at which the idling phase changes are multiples of this.
    localparam int PHASE_ITEMS      = 650;
    localparam int ITEMS_GOAL       = 2000;
    // Cycles allowed after the last expected result.
    localparam int DRAIN_CYCLES     = 100;

    // Data register numbers used by the directed program.
    localparam logic [3:0] REG_V1 = 4'h1;
    localparam logic [3:0] REG_V2 = 4'h2;
    localparam logic [3:0] REG_V3 = 4'h3;
    localparam logic [3:0] REG_VF = 4'hF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // mem_address[11:0], mem_data[19:12], zero pad
    logic [0:0]  s_axis_tuser = '0;     // opcode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // display_request[1:0], sprite_address[13:2],
                                        // sprite_x[21:14], sprite_y[29:22],
                                        // sprite_rows[33:30], fault_pc[45:34], zero pad
    logic [2:0]  m_axis_tuser;          // status[2:0]

    int          open_count;
    int          error_count;

    // Idling percentages of both sides, changed by the stimulus per phase.
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 75;
    logic        long_hold_req = 1'b0;
    logic        hold_taken;
    int          hold_left;
    int          cycle_count = 0;

    // Stimulus-side shadow of the program counter. Every instruction is
    // written into memory right before it is executed, so the stimulus
    // always knows what runs and can keep the core from stopping early.
    logic [11:0] prog_pc = 12'(PROGRAM_START);
    int          sent_items = 0;

    chip8_instruction_subset_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    chip8_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .open_count  (open_count),
        .error_count (error_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result channel backpressure. Once asked, the receiver holds tready low
    // for a long stretch so that the core's output register fills and the
    // input channel stalls while the sender keeps offering transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_req && !hold_taken)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one transfer and returns once it has been accepted. A random
    // gap in front of it may drop tvalid first.
    task automatic send_item(input logic kind, input logic [11:0] addr,
                             input logic [7:0] value);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'h0, value, addr};
        s_axis_tuser <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_items++;
    endtask

    // Writes one instruction at the program counter and executes it. The
    // address and data of the execute transfer are don't-care, so they are
    // random to toggle every input bit on that kind of transfer as well.
    task automatic run_instruction(input logic [15:0] word, input logic advance);
        send_item(OP_WRITE, prog_pc, word[15:8]);
        send_item(OP_WRITE, prog_pc + 12'd1, word[7:0]);
        send_item(OP_EXEC, 12'($urandom), 8'($urandom));
        if (advance)
        begin
            prog_pc = prog_pc + 12'd2;
        end
    endtask

    // A random supported instruction. None of these stops the core.
    function automatic logic [15:0] random_instruction();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return {GRP_SET, 4'($urandom), 8'($urandom)};
        else if (pick < 30)
            return {GRP_ADD, 4'($urandom), 8'($urandom)};
        else if (pick < 40)
            return {GRP_INDEX, 12'($urandom)};
        else if (pick < 55)
            return {GRP_DRAW, 12'($urandom)};
        else if (pick < 62)
            return {GRP_SYS, 4'h0, SYS_CLS};
        else if (pick < 72)
            return {GRP_MISC, 4'($urandom), MISC_FONT};
        else if (pick < 86)
            return {GRP_MISC, 4'($urandom), MISC_BCD};
        else
            return {GRP_MISC, 4'($urandom), MISC_LOAD};
    endfunction

    initial
    begin
        int          pick;
        logic [15:0] stop_word;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Writes at both ends of memory with both extreme
        // data values, then a short program: VF = FF and FF + FF wrapping to
        // FE, the index register set to the top of memory so that the BCD
        // store and the register load wrap around to address zero, a font
        // lookup of a digit that has no glyph, a draw with all fields set,
        // a screen clear, a font lookup of digit zero and a draw of no rows.
        send_item(OP_WRITE, 12'hFFF, 8'hFF);
        send_item(OP_WRITE, 12'h000, 8'h00);
        run_instruction({GRP_SET, REG_VF, 8'hFF}, 1'b1);
        run_instruction({GRP_ADD, REG_VF, 8'hFF}, 1'b1);
        run_instruction({GRP_INDEX, 12'hFFE}, 1'b1);
        run_instruction({GRP_MISC, REG_VF, MISC_BCD}, 1'b1);
        run_instruction({GRP_MISC, REG_VF, MISC_LOAD}, 1'b1);
        run_instruction({GRP_MISC, REG_V1, MISC_FONT}, 1'b1);
        run_instruction({GRP_DRAW, REG_V1, REG_V2, 4'hF}, 1'b1);
        run_instruction({GRP_SYS, 4'h0, SYS_CLS}, 1'b1);
        run_instruction({GRP_MISC, REG_V3, MISC_FONT}, 1'b1);
        run_instruction({GRP_DRAW, REG_V1, REG_V2, 4'h0}, 1'b1);

        // Random part. Mostly well-formed instruction runs with random
        // content; the rest are stray writes into the next program slot and
        // random writes anywhere. It runs until the item goal is reached,
        // passing through all three idling phases on the way.
        while (sent_items < ITEMS_GOAL)
        begin
            if (sent_items < PHASE_ITEMS)
            begin
                tx_idle_pct = 9;
                rx_idle_pct = 75;
            end
            else if (sent_items < 2 * PHASE_ITEMS)
            begin
                tx_idle_pct = 75;
                rx_idle_pct = 9;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                long_hold_req <= 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 85)
                run_instruction(random_instruction(), 1'b1);
            else if (pick < 90)
                send_item(OP_WRITE, prog_pc + 12'($urandom_range(1)), 8'($urandom));
            else
                send_item(OP_WRITE, 12'($urandom), 8'($urandom));
        end

        // Stop the core, either by the render-and-stop instruction or by one
        // of several unimplemented opcodes. The core can not be restarted,
        // so this comes last.
        case ($urandom_range(4))
            0:       stop_word = {GRP_SYS, 4'h0, SYS_RET};
            1:       stop_word = {GRP_SYS, 4'($urandom_range(1, 15)), 8'($urandom)};
            2:       stop_word = {GRP_MISC, 4'($urandom), MISC_KEY};
            3:       stop_word = {GRP_ALU, 12'($urandom)};
            default: stop_word = {GRP_MISC, 4'($urandom), MISC_HALT};
        endcase
        run_instruction(stop_word, 1'b0);

        // A stopped core ignores execute transfers but still takes writes.
        repeat (24)
            send_item(1'($urandom), 12'($urandom), 8'($urandom));
        s_axis_tvalid <= 1'b0;

        while (open_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/c8_pkg.sv
design/c8_store.sv
design/chip8_instruction_subset_core.sv
design/c8_checker.sv
tb/chip8_result_checker.sv
tb/testbench.sv
